// ----- src/rv32ex_pkg.sv -----
package rv32ex_pkg;

	localparam int XLEN          = 32;
	localparam int NUM_REGS      = 32;
	localparam int REG_AW        = 5;
	localparam int MEM_BYTES_DEF = 4096;
	localparam int UPPER_SHIFT   = 12;
	localparam int IN_W          = 88;
	localparam int OUT_W         = 72;

	// Operation codes as they arrive in req_type; codes above OP_SW are not supported.
	typedef enum logic [4:0] {
		OP_ADD   = 5'd0,
		OP_SUB   = 5'd1,
		OP_XOR   = 5'd2,
		OP_OR    = 5'd3,
		OP_AND   = 5'd4,
		OP_SLL   = 5'd5,
		OP_SRL   = 5'd6,
		OP_SRA   = 5'd7,
		OP_SLT   = 5'd8,
		OP_SLTU  = 5'd9,
		OP_ADDI  = 5'd10,
		OP_XORI  = 5'd11,
		OP_ORI   = 5'd12,
		OP_ANDI  = 5'd13,
		OP_SLLI  = 5'd14,
		OP_SRLI  = 5'd15,
		OP_SRAI  = 5'd16,
		OP_SLTI  = 5'd17,
		OP_SLTIU = 5'd18,
		OP_LUI   = 5'd19,
		OP_AUIPC = 5'd20,
		OP_LB    = 5'd21,
		OP_LH    = 5'd22,
		OP_LW    = 5'd23,
		OP_LBU   = 5'd24,
		OP_LHU   = 5'd25,
		OP_SB    = 5'd26,
		OP_SH    = 5'd27,
		OP_SW    = 5'd28
	} op_t;

	// Index of the last byte of an access.
	typedef enum logic [1:0] {
		LB_BYTE = 2'd0,
		LB_HALF = 2'd1,
		LB_WORD = 2'd3
	} last_byte_t;

	typedef struct packed {
		logic       writes;
		logic       is_load;
		logic       is_store;
		logic       unknown;
		last_byte_t last_byte;
		logic       sign_ext;
	} ctrl_t;

	// Request from the execute stage to the data memory.
	typedef struct packed {
		logic            en;
		logic            wr;
		logic [XLEN-1:0] addr;
		logic [XLEN-1:0] wdata;
		last_byte_t      last_byte;
	} dmem_req_t;

	// One register file write.
	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] idx;
		logic [XLEN-1:0]   value;
	} wb_t;

	function automatic ctrl_t decode(input logic [4:0] op);
		ctrl_t c;
		c = '0;
		c.last_byte = LB_WORD;
		unique case (op) inside
			OP_ADD, OP_SUB, OP_XOR, OP_OR, OP_AND, OP_SLL, OP_SRL, OP_SRA, OP_SLT, OP_SLTU,
			OP_ADDI, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI, OP_SLTI, OP_SLTIU,
			OP_LUI, OP_AUIPC: begin
				c.writes = 1'b1;
			end
			OP_LB, OP_LBU, OP_LH, OP_LHU, OP_LW: begin
				c.writes  = 1'b1;
				c.is_load = 1'b1;
				c.last_byte = (op == OP_LB || op == OP_LBU) ? LB_BYTE :
					(op == OP_LH || op == OP_LHU) ? LB_HALF : LB_WORD;
				c.sign_ext = (op == OP_LB || op == OP_LH);
			end
			OP_SB, OP_SH, OP_SW: begin
				c.is_store = 1'b1;
				c.last_byte = (op == OP_SB) ? LB_BYTE : (op == OP_SH) ? LB_HALF : LB_WORD;
			end
			default: begin
				c.unknown = 1'b1;
			end
		endcase
		return c;
	endfunction

endpackage

// ----- src/rv32ex_regfile.sv -----
module rv32ex_regfile
	import rv32ex_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [REG_AW-1:0] rd_addr1,
	input  logic [REG_AW-1:0] rd_addr2,
	input  wb_t               wr,
	output logic [XLEN-1:0]   rd_data1,
	output logic [XLEN-1:0]   rd_data2
);

	logic [XLEN-1:0]     mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [XLEN-1:0]     data1_q, data2_q;
	logic                vld1_q, vld2_q;

	// Entries never written read as zero; x0 is never marked valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld1_q  <= 1'b0;
			vld2_q  <= 1'b0;
		end else begin
			vld1_q <= valid_q[rd_addr1];
			vld2_q <= valid_q[rd_addr2];
			if (wr.en && wr.idx != '0) begin
				valid_q[wr.idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		data1_q <= mem[rd_addr1];
		data2_q <= mem[rd_addr2];
		if (wr.en) begin
			mem[wr.idx] <= wr.value;
		end
	end

	assign rd_data1 = vld1_q ? data1_q : '0;
	assign rd_data2 = vld2_q ? data2_q : '0;

endmodule

// ----- src/rv32ex_alu.sv -----
module rv32ex_alu
	import rv32ex_pkg::*;
(
	input  logic [4:0]      op,
	input  logic [XLEN-1:0] src_a,
	input  logic [XLEN-1:0] src_b,
	input  logic [XLEN-1:0] imm,
	input  logic [XLEN-1:0] pc,
	output logic [XLEN-1:0] result,
	output logic [XLEN-1:0] addr
);

	logic [XLEN-1:0] opb;
	logic [XLEN-1:0] upper;
	logic [4:0]      sh;

	assign opb   = (op <= OP_SLTU) ? src_b : imm;
	assign sh    = opb[4:0];
	assign upper = imm << UPPER_SHIFT;
	assign addr  = src_a + imm;

	always_comb begin
		case (op) inside
			OP_ADD, OP_ADDI:   result = src_a + opb;
			OP_SUB:            result = src_a - opb;
			OP_XOR, OP_XORI:   result = src_a ^ opb;
			OP_OR, OP_ORI:     result = src_a | opb;
			OP_AND, OP_ANDI:   result = src_a & opb;
			OP_SLL, OP_SLLI:   result = src_a << sh;
			OP_SRL, OP_SRLI:   result = src_a >> sh;
			OP_SRA, OP_SRAI:   result = $signed(src_a) >>> sh;
			OP_SLT, OP_SLTI:   result = {{(XLEN-1){1'b0}}, $signed(src_a) < $signed(opb)};
			OP_SLTU, OP_SLTIU: result = {{(XLEN-1){1'b0}}, src_a < opb};
			OP_LUI:            result = upper;
			OP_AUIPC:          result = pc + upper;
			default:           result = '0;
		endcase
	end

endmodule

// ----- src/rv32ex_dmem.sv -----
module rv32ex_dmem
	import rv32ex_pkg::*;
#(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dmem_req_t       req,
	output logic [XLEN-1:0] rdata,
	output logic            busy
);

	localparam int WORDS = MEM_BYTES / 4;
	localparam int WAW   = $clog2(WORDS);

	logic [WAW-1:0] clr_idx_q;
	logic           clr_busy_q;
	logic [1:0]     off_q;
	logic [7:0]     bank_q [4];
	logic [1:0]     off;

	assign off  = req.addr[1:0];
	assign busy = clr_busy_q;

	// Clearing pass: one word of every bank per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + WAW'(1);
			if (clr_idx_q == WAW'(WORDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.en && !req.wr && !clr_busy_q) begin
			off_q <= off;
		end
	end

	// Byte k of an access at address A sits in bank (A + k) mod 4.
	for (genvar j = 0; j < 4; j++) begin : g_bank
		localparam logic [1:0] J = 2'(j);
		logic [7:0]     mem [WORDS];
		logic [1:0]     k;
		logic [WAW-1:0] word;
		logic [WAW-1:0] idx;
		logic           we;
		logic [7:0]     wbyte;

		assign k     = J - off;
		assign word  = req.addr[WAW+1:2] + WAW'(J < off);
		assign idx   = clr_busy_q ? clr_idx_q : word;
		assign we    = clr_busy_q || (req.en && req.wr && (k <= req.last_byte));
		assign wbyte = clr_busy_q ? 8'h00 : req.wdata[8*k +: 8];

		always_ff @(posedge clk) begin
			if (we) begin
				mem[idx] <= wbyte;
			end
			if (req.en && !req.wr && !clr_busy_q) begin
				bank_q[j] <= mem[idx];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_rot
		assign rdata[8*k +: 8] = bank_q[2'(k) + off_q];
	end

endmodule

// ----- src/rv32i_execute_unit.sv -----
// Channel  | Direction | Beat payload
// ---------+-----------+----------------------------------------------------------------
// s_axis   | in        | one decoded instruction: req_type, dest_reg, src1_reg, src2_reg,
//          |           | imm_value, pc_value
// m_axis   | out       | one result: reg_written, written_reg, written_value, mem_stored,
//          |           | mem_address, op_unknown
//
// The unit takes one instruction beat per cycle while s_axis_tready is high. Each beat
// goes to the execute stage register, then to the result stage register, which offers
// the result beat; with no stall, that beat is taken at the next edge. Results leave in
// instruction order. After reset, the data memory is cleared one word of all four byte
// banks per cycle; s_axis_tready stays low until that pass has finished.
// A stall on m_axis holds the result stage and, through it, the execute stage; the input
// side keeps accepting as long as the execute stage can move on in the same cycle.
module rv32i_execute_unit
	import rv32ex_pkg::*;
#(
	// Size of the data memory in bytes; must be a power of two.
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	// [4:0] req_type, [9:5] dest_reg, [14:10] src1_reg, [19:15] src2_reg,
	// [51:20] imm_value, [83:52] pc_value, [87:84] zero
	input  logic [IN_W-1:0] s_axis_tdata,
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	// [0] reg_written, [5:1] written_reg, [37:6] written_value, [38] mem_stored,
	// [70:39] mem_address, [71] op_unknown
	output logic [OUT_W-1:0] m_axis_tdata
);

	// Execute stage registers.
	logic              s1_valid_q;
	logic [4:0]        req_type_s1;
	logic [REG_AW-1:0] dest_s1, src1_s1, src2_s1;
	logic [XLEN-1:0]   imm_s1, pc_s1;

	// Result stage registers.
	logic              s2_valid_q;
	logic              reg_written_s2;
	logic [REG_AW-1:0] written_reg_s2;
	logic [XLEN-1:0]   value_s2;
	logic              is_load_s2;
	last_byte_t        last_byte_s2;
	logic              sign_ext_s2;
	logic              mem_stored_s2;
	logic [XLEN-1:0]   mem_address_s2;
	logic              op_unknown_s2;

	// Last register file write, covering the read that raced with it.
	wb_t wb_last_q;

	logic              s_hs, m_hs, s1_adv;
	logic [REG_AW-1:0] rf_addr1, rf_addr2;
	logic [XLEN-1:0]   rf_a, rf_b, op_a, op_b;
	logic [XLEN-1:0]   alu_result, alu_addr;
	logic [XLEN-1:0]   load_raw, load_value, wb_value;
	logic              writes_s1;
	logic              dmem_busy;
	ctrl_t             ctrl_s1;
	dmem_req_t         dmem_req;
	wb_t               wb;

	assign m_hs   = s2_valid_q && m_axis_tready;
	assign s1_adv = s1_valid_q && (!s2_valid_q || m_axis_tready);
	assign s_axis_tready = !dmem_busy && (!s1_valid_q || s1_adv);
	assign s_hs   = s_axis_tvalid && s_axis_tready;

	// The register file is read every cycle for whatever the execute stage holds next, so
	// the operands track every write made while an instruction waits in that stage.
	assign rf_addr1 = s_hs ? s_axis_tdata[14:10] : src1_s1;
	assign rf_addr2 = s_hs ? s_axis_tdata[19:15] : src2_s1;

	rv32ex_regfile u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr1 (rf_addr1),
		.rd_addr2 (rf_addr2),
		.wr       (wb),
		.rd_data1 (rf_a),
		.rd_data2 (rf_b)
	);

	// Operand bypass: the result stage is the youngest older instruction, then the write
	// that happened at the last edge, then the register file itself.
	always_comb begin
		if (s2_valid_q && reg_written_s2 && written_reg_s2 == src1_s1) begin
			op_a = wb_value;
		end else if (wb_last_q.en && wb_last_q.idx == src1_s1) begin
			op_a = wb_last_q.value;
		end else begin
			op_a = rf_a;
		end
		if (s2_valid_q && reg_written_s2 && written_reg_s2 == src2_s1) begin
			op_b = wb_value;
		end else if (wb_last_q.en && wb_last_q.idx == src2_s1) begin
			op_b = wb_last_q.value;
		end else begin
			op_b = rf_b;
		end
	end

	assign ctrl_s1   = decode(req_type_s1);
	assign writes_s1 = ctrl_s1.writes && (dest_s1 != '0);

	rv32ex_alu u_alu (
		.op     (req_type_s1),
		.src_a  (op_a),
		.src_b  (op_b),
		.imm    (imm_s1),
		.pc     (pc_s1),
		.result (alu_result),
		.addr   (alu_addr)
	);

	// Loads and stores reach the memory once, when the instruction leaves the execute
	// stage; stores therefore land before any younger load reads.
	always_comb begin
		dmem_req.en        = s1_adv && (ctrl_s1.is_load || ctrl_s1.is_store);
		dmem_req.wr        = ctrl_s1.is_store;
		dmem_req.addr      = alu_addr;
		dmem_req.wdata     = op_b;
		dmem_req.last_byte = ctrl_s1.last_byte;
	end

	rv32ex_dmem #(
		.MEM_BYTES (MEM_BYTES)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dmem_req),
		.rdata  (load_raw),
		.busy   (dmem_busy)
	);

	// Load data arrives with byte 0 of the access in the low byte.
	always_comb begin
		case (last_byte_s2)
			LB_BYTE: load_value = {{(XLEN-8){sign_ext_s2 && load_raw[7]}}, load_raw[7:0]};
			LB_HALF: load_value = {{(XLEN-16){sign_ext_s2 && load_raw[15]}}, load_raw[15:0]};
			default: load_value = load_raw;
		endcase
	end

	assign wb_value = !reg_written_s2 ? '0 : (is_load_s2 ? load_value : value_s2);

	always_comb begin
		wb.en    = m_hs && reg_written_s2;
		wb.idx   = written_reg_s2;
		wb.value = wb_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			wb_last_q  <= '0;
		end else begin
			wb_last_q <= wb;
			if (s_hs) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (m_hs) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_hs) begin
			req_type_s1 <= s_axis_tdata[4:0];
			dest_s1     <= s_axis_tdata[9:5];
			src1_s1     <= s_axis_tdata[14:10];
			src2_s1     <= s_axis_tdata[19:15];
			imm_s1      <= s_axis_tdata[51:20];
			pc_s1       <= s_axis_tdata[83:52];
		end
		if (s1_adv) begin
			reg_written_s2 <= writes_s1;
			written_reg_s2 <= writes_s1 ? dest_s1 : '0;
			value_s2       <= (writes_s1 && !ctrl_s1.is_load) ? alu_result : '0;
			is_load_s2     <= ctrl_s1.is_load;
			last_byte_s2   <= ctrl_s1.last_byte;
			sign_ext_s2    <= ctrl_s1.sign_ext;
			mem_stored_s2  <= ctrl_s1.is_store;
			mem_address_s2 <= (ctrl_s1.is_load || ctrl_s1.is_store) ? alu_addr : '0;
			op_unknown_s2  <= ctrl_s1.unknown;
		end
	end

	assign m_axis_tvalid = s2_valid_q;
	assign m_axis_tdata  = {op_unknown_s2, mem_address_s2, mem_stored_s2, wb_value,
		written_reg_s2, reg_written_s2};

endmodule
